// ===== rtl/core/sids_pkg.sv =====
// Shared types, codes and defaults for the sorted ID set block.
`default_nettype none
package sids_pkg;
  localparam int LIST_DEPTH_DEFAULT = 32;

  localparam logic [1:0] CMD_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] CMD_RUN        = 2'd2;
  localparam logic [1:0] CMD_CLEAR      = 2'd3;

  localparam logic [1:0] OP_AND  = 2'd0;
  localparam logic [1:0] OP_OR   = 2'd1;
  localparam logic [1:0] OP_DIFF = 2'd2;
  localparam logic [1:0] OP_XOR  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] id_value;
    logic [1:0]  operation;
  } in_t;

  typedef struct packed {
    logic [31:0] result_id;
    logic        last;
    logic        empty_res;
    logic        overflow;
  } out_t;

  typedef struct packed {
    logic load;
    logic clear;
  } lst_ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/core/sids_cell.sv =====
// One cell of the insertion sorting chain.
`default_nettype none
module sids_cell (
  input  wire         clk,
  input  wire         ins,
  input  wire         valid,
  input  wire  [31:0] x,
  input  wire  [31:0] prev_val,
  input  wire         prev_gt,
  output logic [31:0] val,
  output logic        gt
);
  assign gt = !valid || (val > x);

  always_ff @(posedge clk) begin
    if (ins && gt) begin
      val <= prev_gt ? prev_val : x;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sids_list.sv =====
// Sorted ID list: a chain of cells kept in ascending order, with a count.
`default_nettype none
module sids_list #(
  parameter int LIST_DEPTH = sids_pkg::LIST_DEPTH_DEFAULT,
  localparam int CW = $clog2(LIST_DEPTH + 1),
  localparam int IW = $clog2(LIST_DEPTH)
) (
  input  wire                   clk,
  input  wire                   rst,
  input  sids_pkg::lst_ctrl_t   ctrl,
  input  wire  [31:0]           x,
  input  wire  [IW-1:0]         rd_idx,
  output logic [31:0]           rd_data,
  output logic [CW-1:0]         count,
  output logic                  full
);
  import sids_pkg::*;

  logic [31:0] vals [LIST_DEPTH];
  logic        gts  [LIST_DEPTH];
  logic        ins;

  assign full    = (count == CW'(LIST_DEPTH));
  assign ins     = ctrl.load && !full;
  assign rd_data = vals[rd_idx];

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      sids_cell u_cell (
        .clk(clk), .ins(ins), .valid(count > CW'(g)), .x(x),
        .prev_val(x), .prev_gt(1'b0), .val(vals[g]), .gt(gts[g])
      );
    end else begin : g_body
      sids_cell u_cell (
        .clk(clk), .ins(ins), .valid(count > CW'(g)), .x(x),
        .prev_val(vals[g-1]), .prev_gt(gts[g-1]), .val(vals[g]), .gt(gts[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count <= '0;
    end else if (ins) begin
      count <= count + CW'(1);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sorted_id_set_operations.sv =====
// Top level: load, clear and merge of two sorted ID lists.
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one transaction per
//   command. Loads insert the ID into the chosen list, kept in ascending
//   order by a chain of compare-and-shift cells; a load into a full list
//   is dropped and sets the sticky overflow flag. Clear empties both
//   lists and the flag. Neither gives a result.
//   A run walks both lists with one compare per cycle while the result
//   register has room, and emits results on out channel
//   (out_valid/out_ready/out_data) in ascending order, the last one
//   marked; an empty result gives one item with empty_res set.
//   A merge step that emits nothing gives no result; the merge step is
//   the pacing loop. The in channel is closed for the length of a run.
//   When the receiver stalls, the merge holds and the result register keeps
//   its transaction until taken.
//   Reset empties both lists, clears the flag and drops any run in progress.
`default_nettype none
module sorted_id_set_operations #(
  parameter int LIST_DEPTH = sids_pkg::LIST_DEPTH_DEFAULT,
  localparam int CW = $clog2(LIST_DEPTH + 1),
  localparam int IW = $clog2(LIST_DEPTH)
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_ready,
  input  sids_pkg::in_t  in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output sids_pkg::out_t out_data
);
  import sids_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic          state;
  logic [1:0]    op;
  logic [CW-1:0] pi, pj;
  logic          overflow_seen;
  logic          have_held;
  logic [31:0]   held;

  lst_ctrl_t     lctrl, rctrl;
  logic [31:0]   a, b;
  logic [CW-1:0] na, nb;
  logic          lfull, rfull;
  logic          acc, slot, push;
  logic          li, lj, emit, adv_i, adv_j, done;
  logic [31:0]   ev;

  assign in_ready = (state == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign slot     = !out_valid || out_ready;
  assign push     = (state == ST_RUN) && slot && (done || (emit && have_held));

  assign lctrl.load  = acc && in_data.command == CMD_LOAD_LEFT;
  assign lctrl.clear = acc && in_data.command == CMD_CLEAR;
  assign rctrl.load  = acc && in_data.command == CMD_LOAD_RIGHT;
  assign rctrl.clear = lctrl.clear;

  sids_list #(.LIST_DEPTH(LIST_DEPTH)) u_left (
    .clk(clk), .rst(rst), .ctrl(lctrl), .x(in_data.id_value),
    .rd_idx(pi[IW-1:0]), .rd_data(a), .count(na), .full(lfull)
  );
  sids_list #(.LIST_DEPTH(LIST_DEPTH)) u_right (
    .clk(clk), .rst(rst), .ctrl(rctrl), .x(in_data.id_value),
    .rd_idx(pj[IW-1:0]), .rd_data(b), .count(nb), .full(rfull)
  );

  always_comb begin
    li    = pi < na;
    lj    = pj < nb;
    emit  = 1'b0;
    adv_i = 1'b0;
    adv_j = 1'b0;
    done  = 1'b0;
    ev    = a;
    if (li && lj) begin
      if (a < b) begin
        adv_i = 1'b1;
        emit  = (op != OP_AND);
      end else if (b < a) begin
        adv_j = 1'b1;
        emit  = (op == OP_OR) || (op == OP_XOR);
        ev    = b;
      end else begin
        adv_i = 1'b1;
        adv_j = 1'b1;
        emit  = (op == OP_AND) || (op == OP_OR);
      end
    end else if (li && op != OP_AND) begin
      adv_i = 1'b1;
      emit  = 1'b1;
    end else if (lj && ((op == OP_OR) || (op == OP_XOR))) begin
      adv_j = 1'b1;
      emit  = 1'b1;
      ev    = b;
    end else begin
      done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      have_held     <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            unique case (in_data.command)
              CMD_LOAD_LEFT:  if (lfull) overflow_seen <= 1'b1;
              CMD_LOAD_RIGHT: if (rfull) overflow_seen <= 1'b1;
              CMD_RUN: begin
                state     <= ST_RUN;
                op        <= in_data.operation;
                pi        <= '0;
                pj        <= '0;
                have_held <= 1'b0;
              end
              default: overflow_seen <= 1'b0;
            endcase
          end
        end
        ST_RUN: begin
          if (slot) begin
            if (adv_i) pi <= pi + CW'(1);
            if (adv_j) pj <= pj + CW'(1);
            if (done) begin
              out_data.result_id <= have_held ? held : 32'd0;
              out_data.last      <= 1'b1;
              out_data.empty_res <= !have_held;
              out_data.overflow  <= overflow_seen;
              have_held          <= 1'b0;
              state              <= ST_IDLE;
            end else if (emit) begin
              if (have_held) begin
                out_data.result_id <= held;
                out_data.last      <= 1'b0;
                out_data.empty_res <= 1'b0;
                out_data.overflow  <= overflow_seen;
              end
              held      <= ev;
              have_held <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_run_closed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !in_ready) else $error("input open during run");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (na <= CW'(LIST_DEPTH)) && (nb <= CW'(LIST_DEPTH)))
    else $error("list count beyond depth");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.empty_res) |-> out_data.last)
    else $error("empty result not marked last");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && slot && done) |=> (out_valid && out_data.last))
    else $error("run ended without final item");
endmodule
`default_nettype wire
